FILE: sv/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge
`define PLFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked on the following edge
`define PLFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/plft_pkg.sv
// types and constants for the page-level flash translation block
package plft_pkg;

  localparam int NUM_LBAS   = 1024;
  localparam int PAGE_COUNT = 2048;

  localparam int LBA_IN_W = 16;
  localparam int LBA_W    = (NUM_LBAS > 1) ? $clog2(NUM_LBAS) : 1;
  localparam int PAGE_W   = 11;
  localparam int PIDX_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CNT_W    = $clog2(PAGE_COUNT + 1);
  localparam int FM_W     = PIDX_W + 1;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TRIM  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_RANGE   = 2'd1,
    STS_NOFREE  = 2'd2,
    STS_BADPAGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PG_FREE    = 2'd0,
    PG_VALID   = 2'd1,
    PG_INVALID = 2'd2,
    PG_UNUSED  = 2'd3
  } pg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_PAGE,
    S_ALLOC,
    S_RESULT
  } state_t;

endpackage

FILE: sv/page_level_flash_translation.sv
// page-level flash translation: one read, write or trim request per beat, one result beat back
// A request is taken when in_valid is high and in_stall low; its result follows on the out_
// channel. Requests run one at a time against two single-port tables: the forward map
// (one entry per logical address) and the page status (one entry per physical page).
// A read of a mapped address passes the map and page steps, a write that finds a free page
// the map and allocate steps, a read of an unmapped address, a write with no free page or a
// trim the map step alone, and an unknown action or an out-of-range address goes straight
// to the result step; the tables are read in one step and used in the next, with the read,
// modify and write-back steps done in turn. The next request is taken as soon as the
// result is handed to the output register, even while that beat is still stalled. Free
// pages are handed out strictly in order, so a fill count marks which pages are still free
// and the page status table needs no clearing. After reset the forward map is cleared
// entry by entry with in_stall held high.
module page_level_flash_translation
  import plft_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic [LBA_IN_W-1:0] in_lba,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic                out_mapped,
  output logic [PAGE_W-1:0]   out_phys_page
);

  state_t state_r, state_nxt;

  logic [FM_W-1:0]   fm_mem [NUM_LBAS];
  logic [FM_W-1:0]   fm_q;
  logic              fm_we, fm_re;
  logic [LBA_W-1:0]  fm_waddr, fm_raddr;
  logic [FM_W-1:0]   fm_wdata;

  pg_t               ps_mem [PAGE_COUNT];
  pg_t               ps_q;
  logic              ps_we, ps_re;
  logic [PIDX_W-1:0] ps_waddr, ps_raddr;
  pg_t               ps_wdata;

  logic [LBA_W-1:0]  clr_r;
  logic [CNT_W-1:0]  alloc_cnt_r, alloc_cnt_nxt;
  action_t           act_r;
  logic [LBA_W-1:0]  lba_r;

  status_t           res_status_r, res_status_nxt;
  logic              res_mapped_r, res_mapped_nxt;
  logic [PIDX_W-1:0] res_page_r, res_page_nxt;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              out_mapped_r;
  logic [PAGE_W-1:0] out_page_r;

  logic              accept, out_load, out_range, fm_hit, pg_free, alloc_full;
  logic [PIDX_W-1:0] fm_page, next_page;

  assign accept     = in_valid && !in_stall;
  assign out_load   = (state_r == S_RESULT) && (!out_valid_r || !out_stall);
  assign out_range  = {1'b0, in_lba} >= (LBA_IN_W + 1)'(NUM_LBAS);
  assign fm_hit     = fm_q[FM_W-1];
  assign fm_page    = fm_q[PIDX_W-1:0];
  assign pg_free    = CNT_W'(fm_page) >= alloc_cnt_r;
  assign alloc_full = alloc_cnt_r == CNT_W'(PAGE_COUNT);
  assign next_page  = alloc_cnt_r[PIDX_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == LBA_W'(NUM_LBAS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (action_t'(in_action) == ACT_NONE || out_range) state_nxt = S_RESULT;
          else state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        unique case (act_r)
          ACT_READ:  state_nxt = fm_hit ? S_PAGE : S_RESULT;
          ACT_WRITE: state_nxt = alloc_full ? S_RESULT : S_ALLOC;
          default:   state_nxt = S_RESULT;
        endcase
      end
      S_PAGE:   state_nxt = S_RESULT;
      S_ALLOC:  state_nxt = S_RESULT;
      S_RESULT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // outputs and table accesses
  always_comb begin
    in_stall       = 1'b1;
    fm_we          = 1'b0;
    fm_waddr       = lba_r;
    fm_wdata       = '0;
    fm_re          = 1'b0;
    fm_raddr       = in_lba[LBA_W-1:0];
    ps_we          = 1'b0;
    ps_waddr       = fm_page;
    ps_wdata       = PG_INVALID;
    ps_re          = 1'b0;
    ps_raddr       = fm_page;
    alloc_cnt_nxt  = alloc_cnt_r;
    res_status_nxt = res_status_r;
    res_mapped_nxt = res_mapped_r;
    res_page_nxt   = res_page_r;
    unique case (state_r)
      S_CLEAR: begin
        fm_we    = 1'b1;
        fm_waddr = clr_r;
      end
      S_IDLE: begin
        in_stall       = 1'b0;
        res_status_nxt = STS_OK;
        res_mapped_nxt = 1'b0;
        res_page_nxt   = '0;
        if (accept) begin
          if (action_t'(in_action) == ACT_NONE) res_status_nxt = STS_OK;
          else if (out_range) res_status_nxt = STS_RANGE;
          else fm_re = 1'b1;
        end
      end
      S_MAP: begin
        unique case (act_r)
          ACT_READ: begin
            ps_re = fm_hit;
          end
          ACT_WRITE: begin
            ps_we = fm_hit;
            if (alloc_full) res_status_nxt = STS_NOFREE;
          end
          default: begin
            ps_we = fm_hit;
            fm_we = 1'b1;
          end
        endcase
      end
      S_PAGE: begin
        if (!pg_free && ps_q == PG_VALID) begin
          res_mapped_nxt = 1'b1;
          res_page_nxt   = fm_page;
        end else begin
          res_status_nxt = STS_BADPAGE;
        end
      end
      S_ALLOC: begin
        ps_we          = 1'b1;
        ps_waddr       = next_page;
        ps_wdata       = PG_VALID;
        fm_we          = 1'b1;
        fm_wdata       = {1'b1, next_page};
        alloc_cnt_nxt  = alloc_cnt_r + CNT_W'(1);
        res_mapped_nxt = 1'b1;
        res_page_nxt   = next_page;
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fm_we) fm_mem[fm_waddr] <= fm_wdata;
    if (fm_re) fm_q <= fm_mem[fm_raddr];
  end

  always_ff @(posedge clk) begin
    if (ps_we) ps_mem[ps_waddr] <= ps_wdata;
    if (ps_re) ps_q <= ps_mem[ps_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      alloc_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + LBA_W'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= action_t'(in_action);
      lba_r <= in_lba[LBA_W-1:0];
    end
    res_status_r <= res_status_nxt;
    res_mapped_r <= res_mapped_nxt;
    res_page_r   <= res_page_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_mapped_r <= res_mapped_r;
      out_page_r   <= PAGE_W'(res_page_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_mapped    = out_mapped_r;
  assign out_phys_page = out_page_r;

endmodule

FILE: sv/plft_checker.sv
// port-level checks for the page-level flash translation block, with its bind
`include "assert_macros.svh"

module plft_checker
  import plft_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic              out_mapped,
  input logic [PAGE_W-1:0] out_phys_page
);

  // one request in flight: busy right after an accepted beat
  `PLFT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // a mapped result always reports success
  `PLFT_ASSERT_IMP(a_mapped_ok, clk, rst_n, out_valid && out_mapped, out_status == STS_OK)

  // unmapped results carry page zero
  `PLFT_ASSERT_IMP(a_unmapped_zero, clk, rst_n, out_valid && !out_mapped,
                   out_phys_page == '0)

  // a stalled result beat holds
  `PLFT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_status) && $stable(out_phys_page))

endmodule

bind page_level_flash_translation plft_checker u_plft_checker (.*);

FILE: test/page_level_flash_translation_tb.sv
// self-checking testbench for the page-level flash translation block
module page_level_flash_translation_tb;
  import plft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD = 4;
  localparam int MAX_WAIT = 12;

  typedef struct packed {
    status_t             status;
    logic                mapped;
    logic [PAGE_W-1:0]   page;
  } reply_t;

  typedef struct {
    action_t             act;
    logic [LBA_IN_W-1:0] lba;
    int                  gap;
    bit                  drain;
  } host_cmd_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_action = ACT_READ;
  logic [LBA_IN_W-1:0] in_lba = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_status;
  logic                out_mapped;
  logic [PAGE_W-1:0]   out_phys_page;

  host_cmd_t host_cmds[$];
  reply_t    replies_due[$];
  int        cmds_taken = 0;
  int        replies_seen = 0;
  int        mismatches = 0;
  int        idle_left = 0;
  int        rx_hold = 0;
  bit        drain_next = 1'b0;

  // shadow of the translation tables
  logic              fwd_ok [NUM_LBAS];
  logic [PIDX_W-1:0] fwd_pg [NUM_LBAS];
  pg_t               page_state [PAGE_COUNT];
  logic [PIDX_W-1:0] wr_ptr;
  int unsigned       spare_pages;

  page_level_flash_translation DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_lba        (in_lba),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_mapped    (out_mapped),
    .out_phys_page (out_phys_page)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic reply_t map_request(action_t act, logic [LBA_IN_W-1:0] lba);
    reply_t           r;
    logic [LBA_W-1:0] a;
    int unsigned      probes;
    r.status = STS_OK;
    r.mapped = 1'b0;
    r.page = '0;
    a = lba[LBA_W-1:0];
    if (act == ACT_NONE) return r;
    if (lba >= NUM_LBAS) begin
      r.status = STS_RANGE;
      return r;
    end
    if (act == ACT_READ) begin
      if (fwd_ok[a]) begin
        if (page_state[fwd_pg[a]] != PG_VALID) begin
          r.status = STS_BADPAGE;
        end else begin
          r.mapped = 1'b1;
          r.page = fwd_pg[a];
        end
      end
      return r;
    end
    // write and trim both retire the old page
    if (fwd_ok[a]) page_state[fwd_pg[a]] = PG_INVALID;
    if (act == ACT_TRIM) begin
      fwd_ok[a] = 1'b0;
      return r;
    end
    if (spare_pages == 0) begin
      r.status = STS_NOFREE;
      return r;
    end
    for (probes = 0; probes < PAGE_COUNT && page_state[wr_ptr] != PG_FREE; probes++)
      wr_ptr = (wr_ptr == PAGE_COUNT - 1) ? '0 : wr_ptr + 1'b1;
    if (page_state[wr_ptr] != PG_FREE) begin
      r.status = STS_NOFREE;
      return r;
    end
    page_state[wr_ptr] = PG_VALID;
    fwd_ok[a] = 1'b1;
    fwd_pg[a] = wr_ptr;
    spare_pages--;
    r.mapped = 1'b1;
    r.page = wr_ptr;
    wr_ptr = (wr_ptr == PAGE_COUNT - 1) ? '0 : wr_ptr + 1'b1;
    return r;
  endfunction

  task automatic add(action_t act, logic [LBA_IN_W-1:0] lba);
    host_cmd_t c;
    c.act = act;
    c.lba = lba;
    // stretches with no sender gaps
    c.gap = ((host_cmds.size() / 128) % 5 == 4) ? 0 : $urandom_range(0, MAX_WAIT);
    c.drain = drain_next;
    drain_next = 1'b0;
    host_cmds.push_back(c);
  endtask

  function automatic logic [LBA_IN_W-1:0] pick_lba();
    // a small hot set gives rewrites and stale mappings
    if ($urandom_range(0, 1) == 0) return LBA_IN_W'($urandom_range(0, 15));
    return LBA_IN_W'($urandom_range(0, NUM_LBAS - 1));
  endfunction

  task automatic mixed_traffic(int count);
    int                  target;
    int                  sel;
    logic [LBA_IN_W-1:0] l;
    target = host_cmds.size() + count;
    while (host_cmds.size() < target) begin
      sel = $urandom_range(0, 99);
      l = pick_lba();
      if (sel < 30) begin
        add(ACT_WRITE, l);
        add(ACT_READ, l);
      end else if (sel < 40) begin
        add(ACT_TRIM, l);
        add(ACT_READ, l);
      end else if (sel < 60) begin
        add(ACT_READ, l);
      end else if (sel < 80) begin
        add(ACT_WRITE, l);
      end else if (sel < 88) begin
        add(ACT_TRIM, l);
      end else if (sel < 95) begin
        add(action_t'($urandom_range(0, 3)),
            LBA_IN_W'($urandom_range(NUM_LBAS, 2**LBA_IN_W - 1)));
      end else begin
        add(ACT_NONE, LBA_IN_W'($urandom_range(0, 2**LBA_IN_W - 1)));
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive
    host_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        replies_due.push_back(map_request(action_t'(in_action), in_lba));
        cmds_taken <= cmds_taken + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (host_cmds.size() > 0 &&
                     (!host_cmds[0].drain || (!in_valid && cmds_taken == replies_seen))) begin
          c = host_cmds.pop_front();
          in_action <= c.act;
          in_lba <= c.lba;
          in_valid <= 1'b1;
          idle_left = c.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor and checker
  always @(posedge clk) begin : observe
    reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen <= replies_seen + 1;
        if (replies_due.size() == 0) begin
          $error("reply beat with no request outstanding");
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            mismatches++;
          end
          if (out_mapped !== want.mapped) begin
            $error("mapped: expected %0d, actual %0d", want.mapped, out_mapped);
            mismatches++;
          end
          if (out_phys_page !== want.page) begin
            $error("phys_page: expected %0d, actual %0d", want.page, out_phys_page);
            mismatches++;
          end
        end
        rx_hold = ((replies_seen / 150) % 4 == 2) ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold > 0);
    end
  end

  initial begin : stimulus
    int i;
    for (i = 0; i < NUM_LBAS; i++) begin
      fwd_ok[i] = 1'b0;
      fwd_pg[i] = '0;
    end
    for (i = 0; i < PAGE_COUNT; i++) page_state[i] = PG_FREE;
    wr_ptr = '0;
    spare_pages = PAGE_COUNT;

    // directed
    add(ACT_READ, 0);
    add(ACT_READ, NUM_LBAS - 1);
    add(ACT_WRITE, 0);
    add(ACT_READ, 0);
    add(ACT_WRITE, 0);
    add(ACT_READ, 0);
    add(ACT_WRITE, NUM_LBAS - 1);
    add(ACT_READ, NUM_LBAS - 1);
    add(ACT_TRIM, 0);
    add(ACT_READ, 0);
    add(ACT_TRIM, 0);
    add(ACT_NONE, 0);
    add(ACT_NONE, 16'hFFFF);
    add(ACT_READ, NUM_LBAS);
    add(ACT_WRITE, 16'hFFFF);
    add(ACT_TRIM, NUM_LBAS);
    add(ACT_WRITE, 16'h8000);
    add(ACT_READ, 16'h5555);
    add(ACT_TRIM, 16'hAAAA);
    add(ACT_WRITE, 16'h0155);
    add(ACT_READ, 16'h0155);

    drain_next = 1'b1;
    mixed_traffic(600);

    // second round once everything outstanding has come back
    drain_next = 1'b1;
    mixed_traffic(530);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (host_cmds.size() != 0 || in_valid || cmds_taken != replies_seen);
    repeat (16) @(posedge clk);

    if (replies_due.size() != 0) begin
      $error("%0d replies never arrived", replies_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/plft_pkg.sv
sv/page_level_flash_translation.sv
sv/plft_checker.sv
test/page_level_flash_translation_tb.sv
